>>> hdl/osd_pkg.sv
// Shared constants, types and command format of the OSD overlay generator.
// Used by the channel interfaces and by every module of the block.
package osd_pkg;

  localparam int GRID_COLS    = 60;
  localparam int GRID_ROWS    = 22;
  localparam int GLYPH_WIDTH  = 24;
  localparam int GLYPH_HEIGHT = 36;
  localparam int GLYPH_COUNT  = 256;

  localparam int OP_W       = 2;
  localparam int CODE_W     = 16;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 11;
  localparam int RGBA_W     = 32;
  localparam int PIX_W      = 8;
  localparam int MARGIN_W   = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = MARGIN_W;

  localparam logic [MARGIN_W-1:0] TOP_MARGIN_RST  = MARGIN_W'(9);
  localparam logic [MARGIN_W-1:0] LEFT_MARGIN_RST = MARGIN_W'(0);

  localparam int GLYPH_SIZE = GLYPH_WIDTH * GLYPH_HEIGHT;
  localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_SIZE;
  localparam int FONT_AW    = $clog2(FONT_DEPTH);
  localparam int GOFF_W     = $clog2(GLYPH_SIZE);
  localparam int MAP_DEPTH  = GRID_COLS * GRID_ROWS;
  localparam int MAP_AW     = $clog2(MAP_DEPTH);
  localparam int GLYPH_W    = 8;
  localparam int CELL_W     = GLYPH_W + 1;

  // Reciprocal division of the grid coordinates by the glyph size.
  localparam int DIV_SH_Y = ROW_W + 1;
  localparam int DIV_SH_X = COL_W + 1;
  localparam int RECIP_Y  = (2 ** DIV_SH_Y) / GLYPH_HEIGHT;
  localparam int RECIP_X  = (2 ** DIV_SH_X) / GLYPH_WIDTH;
  localparam int QY_W     = $clog2((2 ** ROW_W) / GLYPH_HEIGHT + 1);
  localparam int QX_W     = $clog2((2 ** COL_W) / GLYPH_WIDTH + 1);
  localparam int REMY_W   = $clog2(2 * GLYPH_HEIGHT);
  localparam int REMX_W   = $clog2(2 * GLYPH_WIDTH);
  localparam int YW_W     = $clog2((2 ** ROW_W - 1) * GLYPH_WIDTH + 1);

  // Color conversion.
  localparam int SUM_W     = 18;
  localparam int ROUND_OFS = 128;
  localparam int Y_BIAS    = 16;
  localparam int UV_BIAS   = 128;
  localparam int CY_R = 66;
  localparam int CY_G = 129;
  localparam int CY_B = 25;
  localparam int CU_R = -38;
  localparam int CU_G = -74;
  localparam int CU_B = 112;
  localparam int CV_R = 112;
  localparam int CV_G = -94;
  localparam int CV_B = -18;

  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);
  localparam int QL_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_FONT_WR = 2'd0,
    OP_CELL_WR = 2'd1,
    OP_FETCH   = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOP_MARGIN  = 1'b0,
    CFG_LEFT_MARGIN = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    op_t                 kind;
    logic                hit;
    logic [MAP_AW-1:0]   map_addr;
    logic [FONT_AW-1:0]  font_addr;
    logic [RGBA_W-1:0]   data;
  } cmd_t;

  typedef struct packed {
    logic [QL_W-1:0] level;
    logic            clearing;
  } flow_stat_t;

endpackage

>>> hdl/osd_if.sv
// Valid/ready channel interfaces for the input beats and the result beats.
// Depends on osd_pkg for the field widths.
interface osd_in_if import osd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [CODE_W-1:0]   index_code;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    col;
  logic [RGBA_W-1:0]   pixel_rgba;

  modport source (output valid, opcode, index_code, row, col, pixel_rgba, input ready);
  modport sink   (input valid, opcode, index_code, row, col, pixel_rgba, output ready);
endinterface

interface osd_out_if import osd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] luma;
  logic [PIX_W-1:0] chroma_u;
  logic [PIX_W-1:0] chroma_v;
  logic [PIX_W-1:0] alpha;
  logic             covered;

  modport source (output valid, luma, chroma_u, chroma_v, alpha, covered, input ready);
  modport sink   (input valid, luma, chroma_u, chroma_v, alpha, covered, output ready);
endinterface

>>> hdl/osd_front.sv
// Front end: accepts input beats, holds the margin registers, converts
// colors, locates cells and pushes commands into the queue. Uses osd_pkg.
module osd_front import osd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  osd_in_if.sink                 in_ch,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  flow_stat_t             stat,
  output logic                   push,
  output cmd_t                   push_cmd
);

  function automatic logic [PIX_W-1:0] scale_bias(input logic signed [SUM_W-1:0] sum,
                                                  input logic [PIX_W-1:0] bias);
    logic signed [SUM_W-1:0] sh;
    sh = (sum + SUM_W'(ROUND_OFS)) >>> PIX_W;
    return sh[PIX_W-1:0] + bias;
  endfunction

  logic [MARGIN_W-1:0] top_margin_r, left_margin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_margin_r  <= TOP_MARGIN_RST;
      left_margin_r <= LEFT_MARGIN_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_TOP_MARGIN:  top_margin_r  <= cfg_data;
        CFG_LEFT_MARGIN: left_margin_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic f1_valid_r;
  logic acc;
  op_t  op;

  assign in_ch.ready = !stat.clearing &&
                       (int'(stat.level) + int'(f1_valid_r) < QUEUE_DEPTH);
  assign acc = in_ch.valid && in_ch.ready;
  assign op  = op_t'(in_ch.opcode);

  logic signed [SUM_W-1:0] r_s, g_s, b_s, sum_y, sum_u, sum_v;
  logic [RGBA_W-1:0]       yuva;

  assign r_s = signed'(SUM_W'(in_ch.pixel_rgba[PIX_W-1:0]));
  assign g_s = signed'(SUM_W'(in_ch.pixel_rgba[2*PIX_W-1:PIX_W]));
  assign b_s = signed'(SUM_W'(in_ch.pixel_rgba[3*PIX_W-1:2*PIX_W]));
  assign sum_y = SUM_W'(CY_R * r_s + CY_G * g_s + CY_B * b_s);
  assign sum_u = SUM_W'(CU_R * r_s + CU_G * g_s + CU_B * b_s);
  assign sum_v = SUM_W'(CV_R * r_s + CV_G * g_s + CV_B * b_s);
  assign yuva  = {in_ch.pixel_rgba[4*PIX_W-1:3*PIX_W],
                  scale_bias(sum_v, PIX_W'(UV_BIAS)),
                  scale_bias(sum_u, PIX_W'(UV_BIAS)),
                  scale_bias(sum_y, PIX_W'(Y_BIAS))};

  logic [ROW_W-1:0] y_d;
  logic [COL_W-1:0] x_d;
  logic             fetch_hit, fw_ok, cw_ok;
  logic [CELL_W-1:0] cell_word;

  assign y_d = in_ch.row - ROW_W'(top_margin_r);
  assign x_d = in_ch.col - COL_W'(left_margin_r);
  assign fetch_hit = (in_ch.row >= ROW_W'(top_margin_r)) &&
                     (in_ch.col >= COL_W'(left_margin_r)) &&
                     (int'(y_d) < GRID_ROWS * GLYPH_HEIGHT) &&
                     (int'(x_d) < GRID_COLS * GLYPH_WIDTH);
  assign fw_ok = (int'(in_ch.index_code) < GLYPH_COUNT) &&
                 (int'(in_ch.row) < GLYPH_HEIGHT) && (int'(in_ch.col) < GLYPH_WIDTH);
  assign cw_ok = (int'(in_ch.row) < GRID_ROWS) && (int'(in_ch.col) < GRID_COLS);
  assign cell_word = {(in_ch.index_code != '0), in_ch.index_code[GLYPH_W-1:0]};

  logic                f1_valid_nxt, f1_ok_nxt;
  logic [RGBA_W-1:0]   f1_data_nxt;
  op_t                 f1_kind_r;
  logic                f1_ok_r;
  logic [MAP_AW-1:0]   f1_map_addr_r;
  logic [FONT_AW-1:0]  f1_font_addr_r;
  logic [RGBA_W-1:0]   f1_data_r;
  logic [QY_W-1:0]     f1_q0y_r;
  logic [QX_W-1:0]     f1_q0x_r;
  logic [ROW_W-1:0]    f1_y_r;
  logic [COL_W-1:0]    f1_x_r;
  logic [YW_W-1:0]     f1_yw_r;

  always_comb begin
    f1_valid_nxt = 1'b0;
    f1_ok_nxt    = 1'b1;
    f1_data_nxt  = yuva;
    case (op)
      OP_FONT_WR: f1_valid_nxt = acc && fw_ok;
      OP_CELL_WR: begin
        f1_valid_nxt = acc && cw_ok;
        f1_data_nxt  = RGBA_W'(cell_word);
      end
      OP_FETCH: begin
        f1_valid_nxt = acc;
        f1_ok_nxt    = fetch_hit;
      end
      default: f1_valid_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= f1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f1_kind_r      <= op;
    f1_ok_r        <= f1_ok_nxt;
    f1_data_r      <= f1_data_nxt;
    f1_map_addr_r  <= MAP_AW'(int'(in_ch.row) * GRID_COLS + int'(in_ch.col));
    f1_font_addr_r <= FONT_AW'(int'(in_ch.index_code[GLYPH_W-1:0]) * GLYPH_SIZE +
                               int'(in_ch.row) * GLYPH_WIDTH + int'(in_ch.col));
    f1_q0y_r       <= QY_W'((int'(y_d) * RECIP_Y) >> DIV_SH_Y);
    f1_q0x_r       <= QX_W'((int'(x_d) * RECIP_X) >> DIV_SH_X);
    f1_y_r         <= y_d;
    f1_x_r         <= x_d;
    f1_yw_r        <= YW_W'(int'(y_d) * GLYPH_WIDTH);
  end

  // The reciprocal quotient is low by at most one; one correction step fixes it.
  logic [REMY_W-1:0] r0y;
  logic [REMX_W-1:0] r0x;
  logic              inc_y, inc_x;
  logic [MAP_AW-1:0] fetch_cell;
  logic [GOFF_W-1:0] fetch_off;

  assign r0y   = REMY_W'(int'(f1_y_r) - int'(f1_q0y_r) * GLYPH_HEIGHT);
  assign r0x   = REMX_W'(int'(f1_x_r) - int'(f1_q0x_r) * GLYPH_WIDTH);
  assign inc_y = int'(r0y) >= GLYPH_HEIGHT;
  assign inc_x = int'(r0x) >= GLYPH_WIDTH;
  assign fetch_cell = MAP_AW'(int'(f1_q0y_r) * GRID_COLS + int'(f1_q0x_r) +
                              (inc_y ? GRID_COLS : 0) + (inc_x ? 1 : 0));
  assign fetch_off = GOFF_W'(int'(f1_yw_r) - int'(f1_q0y_r) * GLYPH_SIZE -
                             (inc_y ? GLYPH_SIZE : 0) + int'(r0x) -
                             (inc_x ? GLYPH_WIDTH : 0));

  always_comb begin
    push               = f1_valid_r;
    push_cmd.kind      = f1_kind_r;
    push_cmd.hit       = f1_ok_r;
    push_cmd.data      = f1_data_r;
    push_cmd.map_addr  = f1_map_addr_r;
    push_cmd.font_addr = f1_font_addr_r;
    if (f1_kind_r == OP_FETCH) begin
      push_cmd.map_addr  = fetch_cell;
      push_cmd.font_addr = FONT_AW'(fetch_off);
    end
  end

endmodule

>>> hdl/osd_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Uses the cmd_t format and depth from osd_pkg.
module osd_cmd_fifo import osd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cmd_t             push_cmd,
  input  logic             pop,
  output logic             head_valid,
  output cmd_t             head,
  output logic [QL_W-1:0]  level
);

  cmd_t            entry_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QL_W-1:0] level_r;
  logic            do_pop;

  assign do_pop     = pop && (level_r != '0);
  assign head_valid = level_r != '0;
  assign head       = entry_r[rd_ptr_r];
  assign level      = level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      level_r <= level_r + QL_W'(push) - QL_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> hdl/osd_back.sv
// Back end: character map and font store, the two-stage lookup pipeline and
// the result register. Clears the character map after reset. Uses osd_pkg.
module osd_back import osd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  cmd_t       head,
  output logic       pop,
  output logic       clearing,
  osd_out_if.source  out_ch
);

  logic [CELL_W-1:0] cell_mem [MAP_DEPTH];
  logic [RGBA_W-1:0] font_mem [FONT_DEPTH];

  logic              clr_r;
  logic [MAP_AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      if (clr_addr_r == MAP_AW'(MAP_DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign clearing = clr_r;

  logic adv;
  logic s2_valid_r;

  assign adv = !s2_valid_r || out_ch.ready;
  assign pop = head_valid && adv && !clr_r;

  logic [CELL_W-1:0] cell_rd_r;

  always_ff @(posedge clk) begin
    if (clr_r) begin
      cell_mem[clr_addr_r] <= '0;
    end else if (pop && head.kind == OP_CELL_WR) begin
      cell_mem[head.map_addr] <= head.data[CELL_W-1:0];
    end
    if (pop) begin
      cell_rd_r <= cell_mem[head.map_addr];
    end
  end

  logic               s1_valid_r;
  op_t                s1_kind_r;
  logic               s1_hit_r;
  logic [FONT_AW-1:0] s1_font_addr_r;
  logic [RGBA_W-1:0]  s1_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_kind_r      <= head.kind;
      s1_hit_r       <= head.hit;
      s1_font_addr_r <= head.font_addr;
      s1_data_r      <= head.data;
    end
  end

  logic [GLYPH_W-1:0]  glyph;
  logic                cov, pix_ok, font_we;
  logic [FONT_AW-1:0]  font_raddr;

  assign glyph      = cell_rd_r[GLYPH_W-1:0];
  assign cov        = s1_hit_r && cell_rd_r[CELL_W-1];
  assign pix_ok     = cov && (int'(glyph) < GLYPH_COUNT);
  assign font_raddr = FONT_AW'(int'(glyph) * GLYPH_SIZE +
                               int'(s1_font_addr_r[GOFF_W-1:0]));
  assign font_we    = adv && s1_valid_r && (s1_kind_r == OP_FONT_WR);

  logic [RGBA_W-1:0] font_rd_r;
  logic              s2_cov_r, s2_pix_ok_r;

  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[s1_font_addr_r] <= s1_data_r;
    end
    if (adv && s1_valid_r && (s1_kind_r == OP_FETCH)) begin
      font_rd_r <= font_mem[font_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r && (s1_kind_r == OP_FETCH);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cov_r    <= cov;
      s2_pix_ok_r <= pix_ok;
    end
  end

  assign out_ch.valid    = s2_valid_r;
  assign out_ch.covered  = s2_cov_r;
  assign out_ch.luma     = s2_pix_ok_r ? font_rd_r[PIX_W-1:0] : '0;
  assign out_ch.chroma_u = s2_pix_ok_r ? font_rd_r[2*PIX_W-1:PIX_W] : '0;
  assign out_ch.chroma_v = s2_pix_ok_r ? font_rd_r[3*PIX_W-1:2*PIX_W] : '0;
  assign out_ch.alpha    = s2_pix_ok_r ? font_rd_r[4*PIX_W-1:3*PIX_W] : '0;

`ifndef NO_ASSERTIONS
  a_no_cmd_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !head_valid)
    else $error("command queued during character map clear");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !out_ch.ready |=> s2_valid_r &&
                                    $stable({out_ch.luma, out_ch.chroma_u, out_ch.chroma_v,
                                             out_ch.alpha, out_ch.covered}))
    else $error("stalled result changed");

  a_lookup_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_kind_r) && $stable(s1_font_addr_r))
    else $error("stalled cell lookup lost");
`endif

endmodule

>>> hdl/osd_character_overlay_generator_top.sv
// Top level of the text-mode OSD overlay generator.
// Depends on osd_pkg, osd_if, osd_front, osd_cmd_fifo and osd_back.
//
// The block takes one input beat per clock and delivers one result beat per
// clock for a stream of pixel fetches while the result side is ready; a fetch
// result passes the front-end register, the command queue, the cell read and
// the font read. The rate is set by the single-port character map and font
// store, each touched at most once per command in its own pipeline stage.
// After reset the character map is swept to zero, one cell per cycle, over all
// 1320 cells; input ready stays low during the sweep, margin writes go as usual.
module osd_character_overlay_generator_top import osd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  osd_in_if.sink                 in_ch,
  osd_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic            push, pop, head_valid, clearing;
  cmd_t            push_cmd, head;
  logic [QL_W-1:0] level;
  flow_stat_t      stat;

  assign stat.level    = level;
  assign stat.clearing = clearing;

  osd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .stat     (stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  osd_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .level      (level)
  );

  osd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .clearing   (clearing),
    .out_ch     (out_ch)
  );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the OSD character overlay generator top level.
// Drives font, cell and fetch beats with random bursts and stalls, and checks
// every fetch result against an in-bench model. Depends on osd_pkg and osd_if.
module testbench;
  import osd_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_BEATS  = 150;
  localparam int REPORT_CAP   = 40;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_u;
    logic [PIX_W-1:0] chroma_v;
    logic [PIX_W-1:0] alpha;
    logic             covered;
  } overlay_pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  osd_in_if  in_if ();
  osd_out_if out_if ();

  osd_character_overlay_generator_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [RGBA_W-1:0]   font_yuva [FONT_DEPTH];
  bit                  font_loaded [FONT_DEPTH];
  logic [CELL_W-1:0]   char_map [MAP_DEPTH];
  logic [MARGIN_W-1:0] top_rows;
  logic [MARGIN_W-1:0] left_cols;
  overlay_pixel_t      pending_pixels [$];
  overlay_pixel_t      next_pixel;

  int errors;
  int beats_sent;
  int live_beats;
  int pixels_checked;
  int covered_seen;
  int burst_left;
  int cycle_count;
  int margin_settings;

  function automatic logic [PIX_W-1:0] scale_offset(int sum, int bias);
    return PIX_W'(((sum + 128) >>> 8) + bias);
  endfunction

  function automatic logic [RGBA_W-1:0] rgba_to_yuva(logic [RGBA_W-1:0] rgba);
    int r;
    int g;
    int b;
    r = int'(rgba[7:0]);
    g = int'(rgba[15:8]);
    b = int'(rgba[23:16]);
    return {rgba[31:24],
            scale_offset(112 * r - 94 * g - 18 * b, 128),
            scale_offset(-38 * r - 74 * g + 112 * b, 128),
            scale_offset(66 * r + 129 * g + 25 * b, 16)};
  endfunction

  function automatic int font_addr(int glyph, int line, int gx);
    return (glyph * GLYPH_HEIGHT + line) * GLYPH_WIDTH + gx;
  endfunction

  // Returns the font address shown at an overlay coordinate, or -1 when none is.
  function automatic int lookup_glyph_pixel(input int row, input int col, output bit hit);
    int y;
    int x;
    int cr;
    int cc;
    logic [CELL_W-1:0] entry;
    hit = 1'b0;
    if (row < int'(top_rows) || col < int'(left_cols)) return -1;
    y = row - int'(top_rows);
    x = col - int'(left_cols);
    cr = y / GLYPH_HEIGHT;
    cc = x / GLYPH_WIDTH;
    if (cr >= GRID_ROWS || cc >= GRID_COLS) return -1;
    entry = char_map[cr * GRID_COLS + cc];
    if (!entry[CELL_W-1]) return -1;
    hit = 1'b1;
    if (int'(entry[GLYPH_W-1:0]) >= GLYPH_COUNT) return -1;
    return font_addr(int'(entry[GLYPH_W-1:0]), y % GLYPH_HEIGHT, x % GLYPH_WIDTH);
  endfunction

  task automatic apply_beat(logic [OP_W-1:0] op, logic [CODE_W-1:0] code,
                            logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                            logic [RGBA_W-1:0] rgba);
    int addr;
    bit hit;
    overlay_pixel_t px;
    case (op)
      OP_FONT_WR: begin
        if (code < GLYPH_COUNT && row < GLYPH_HEIGHT && col < GLYPH_WIDTH) begin
          addr = font_addr(int'(code), int'(row), int'(col));
          font_yuva[addr] = rgba_to_yuva(rgba);
          font_loaded[addr] = 1'b1;
          live_beats++;
        end
      end
      OP_CELL_WR: begin
        if (row < GRID_ROWS && col < GRID_COLS) begin
          char_map[int'(row) * GRID_COLS + int'(col)] = {code != '0, code[GLYPH_W-1:0]};
          live_beats++;
        end
      end
      OP_FETCH: begin
        addr = lookup_glyph_pixel(int'(row), int'(col), hit);
        px = '0;
        px.covered = hit;
        if (addr >= 0) {px.alpha, px.chroma_v, px.chroma_u, px.luma} = font_yuva[addr];
        pending_pixels.push_back(px);
        live_beats++;
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_beat(logic [OP_W-1:0] op, logic [CODE_W-1:0] code,
                           logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                           logic [RGBA_W-1:0] rgba);
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.index_code <= code;
    in_if.row        <= row;
    in_if.col        <= col;
    in_if.pixel_rgba <= rgba;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    apply_beat(op, code, row, col, rgba);
    beats_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
    end
  endtask

  // A fetch that would show a font word never loaded gets that word loaded first.
  task automatic fetch_pixel(int row, int col);
    int addr;
    bit hit;
    addr = lookup_glyph_pixel(row, col, hit);
    if (addr >= 0 && !font_loaded[addr])
      send_beat(OP_FONT_WR, CODE_W'(addr / GLYPH_SIZE),
                ROW_W'((addr / GLYPH_WIDTH) % GLYPH_HEIGHT),
                COL_W'(addr % GLYPH_WIDTH), $urandom);
    send_beat(OP_FETCH, CODE_W'($urandom), ROW_W'(row), COL_W'(col), $urandom);
  endtask

  task automatic fetch_in_cell(int cr, int cc, int line, int gx);
    fetch_pixel(int'(top_rows) + cr * GLYPH_HEIGHT + line,
                int'(left_cols) + cc * GLYPH_WIDTH + gx);
  endtask

  task automatic drain_pipeline();
    in_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [MARGIN_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_TOP_MARGIN) top_rows = value;
    else left_cols = value;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < REPORT_CAP)
      $display("%0t: mismatch on %s, got %0h, expected %0h (result %0d)",
               $realtime, what, got, want, pixels_checked);
    errors++;
  endtask

  task automatic test_empty_map();
    fetch_pixel(0, 0);
    fetch_pixel(9, 0);
    fetch_pixel(1023, 2047);
    fetch_in_cell(GRID_ROWS - 1, GRID_COLS - 1, GLYPH_HEIGHT - 1, GLYPH_WIDTH - 1);
  endtask

  task automatic test_glyph_corners();
    send_beat(OP_CELL_WR, 16'h0001, 10'd0, 11'd0, $urandom);
    send_beat(OP_FONT_WR, 16'd1, 10'd0, 11'd0, 32'hFFFF_FFFF);
    fetch_in_cell(0, 0, 0, 0);
    send_beat(OP_FONT_WR, 16'd1, 10'd35, 11'd23, 32'h0000_0000);
    fetch_in_cell(0, 0, GLYPH_HEIGHT - 1, GLYPH_WIDTH - 1);
    // A code above 0xFF still covers its cell and shows the glyph of its low byte.
    send_beat(OP_CELL_WR, 16'h0100, 10'd21, 11'd59, $urandom);
    send_beat(OP_FONT_WR, 16'd0, 10'd0, 11'd0, 32'h8000_00FF);
    fetch_in_cell(GRID_ROWS - 1, GRID_COLS - 1, 0, 0);
    send_beat(OP_CELL_WR, 16'hFFFF, 10'd0, 11'd1, $urandom);
    send_beat(OP_FONT_WR, 16'd255, 10'd35, 11'd23, 32'h7FFF_0000);
    fetch_in_cell(0, 1, GLYPH_HEIGHT - 1, GLYPH_WIDTH - 1);
    send_beat(OP_FONT_WR, 16'd255, 10'd0, 11'd0, 32'h0000_FF00);
    fetch_in_cell(0, 1, 0, 0);
  endtask

  task automatic test_ignored_writes();
    send_beat(OP_FONT_WR, 16'd256, 10'd0, 11'd0, $urandom);
    send_beat(OP_FONT_WR, 16'd0, 10'd36, 11'd0, $urandom);
    send_beat(OP_FONT_WR, 16'd0, 10'd0, 11'd24, $urandom);
    send_beat(OP_FONT_WR, 16'hFFFF, 10'h3FF, 11'h7FF, 32'hFFFF_FFFF);
    send_beat(OP_CELL_WR, 16'd5, 10'd22, 11'd0, $urandom);
    send_beat(OP_CELL_WR, 16'd5, 10'd0, 11'd60, $urandom);
    send_beat(OP_CELL_WR, 16'hFFFF, 10'h3FF, 11'h7FF, $urandom);
    send_beat(OP_UNUSED, 16'hFFFF, 10'h3FF, 11'h7FF, 32'hFFFF_FFFF);
    fetch_in_cell(0, 0, 0, 0);
    fetch_in_cell(GRID_ROWS - 1, GRID_COLS - 1, 0, 0);
  endtask

  task automatic test_grid_edges();
    send_beat(OP_CELL_WR, 16'h0000, 10'd0, 11'd0, $urandom);
    fetch_in_cell(0, 0, 0, 0);
    if (top_rows != '0) fetch_pixel(int'(top_rows) - 1, int'(left_cols));
    if (left_cols != '0) fetch_pixel(int'(top_rows), int'(left_cols) - 1);
    fetch_in_cell(GRID_ROWS, 0, 0, 0);
    fetch_in_cell(0, GRID_COLS, 0, 0);
  endtask

  task automatic random_traffic(int target);
    int goal;
    int pick;
    int cr;
    int cc;
    logic [OP_W-1:0] op;
    goal = live_beats + target;
    while (live_beats < goal) begin
      pick = $urandom_range(0, 99);
      cr = $urandom_range(0, GRID_ROWS - 1);
      cc = $urandom_range(0, GRID_COLS - 1);
      if (pick < 40) begin
        fetch_in_cell(cr, cc, $urandom_range(0, GLYPH_HEIGHT - 1),
                      $urandom_range(0, GLYPH_WIDTH - 1));
      end else if (pick < 55) begin
        send_beat(OP_CELL_WR, CODE_W'($urandom_range(1, 65535)), ROW_W'(cr), COL_W'(cc),
                  $urandom);
        repeat ($urandom_range(2, 4))
          fetch_in_cell(cr, cc, $urandom_range(0, GLYPH_HEIGHT - 1),
                        $urandom_range(0, GLYPH_WIDTH - 1));
      end else if (pick < 65) begin
        send_beat(OP_FONT_WR, CODE_W'($urandom_range(0, GLYPH_COUNT - 1)),
                  ROW_W'($urandom_range(0, GLYPH_HEIGHT - 1)),
                  COL_W'($urandom_range(0, GLYPH_WIDTH - 1)), $urandom);
      end else if (pick < 75) begin
        send_beat(OP_CELL_WR,
                  ($urandom_range(0, 7) == 0) ? '0 : CODE_W'($urandom_range(1, 65535)),
                  ROW_W'(cr), COL_W'(cc), $urandom);
      end else if (pick < 85) begin
        fetch_pixel($urandom_range(0, 1023), $urandom_range(0, 2047));
      end else begin
        op = OP_W'($urandom_range(0, 3));
        if (op == OP_FETCH) fetch_pixel($urandom_range(0, 1023), $urandom_range(0, 2047));
        else send_beat(op, CODE_W'($urandom), ROW_W'($urandom), COL_W'($urandom), $urandom);
      end
    end
  endtask

  task automatic test_margin_phases();
    int tops [7];
    int lefts [7];
    tops  = '{0, 63, 9, 0, 63, 0, 0};
    lefts = '{0, 63, 0, 63, 0, 0, 0};
    tops[5]  = $urandom_range(0, 63);
    lefts[5] = $urandom_range(0, 63);
    tops[6]  = $urandom_range(0, 63);
    lefts[6] = $urandom_range(0, 63);
    for (int p = 0; p < 7; p++) begin
      drain_pipeline();
      write_reg(CFG_TOP_MARGIN, MARGIN_W'(tops[p]));
      write_reg(CFG_LEFT_MARGIN, MARGIN_W'(lefts[p]));
      margin_settings++;
      test_grid_edges();
      random_traffic(PHASE_BEATS);
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_TOP_MARGIN;
    cfg_data         <= '0;
    in_if.valid      <= 1'b0;
    in_if.opcode     <= OP_FONT_WR;
    in_if.index_code <= '0;
    in_if.row        <= '0;
    in_if.col        <= '0;
    in_if.pixel_rgba <= '0;
    errors = 0;
    beats_sent = 0;
    live_beats = 0;
    pixels_checked = 0;
    covered_seen = 0;
    margin_settings = 0;
    burst_left = 1;
    top_rows = TOP_MARGIN_RST;
    left_cols = LEFT_MARGIN_RST;
    foreach (char_map[i]) char_map[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_map();
    test_glyph_corners();
    test_ignored_writes();
    test_grid_edges();
    test_margin_phases();
    drain_pipeline();
    $display("Sent %0d beats, %0d of them effective, under %0d margin settings.",
             beats_sent, live_beats, margin_settings);
    $display("Checked %0d fetched pixels, %0d covered by a character.",
             pixels_checked, covered_seen);
    if (errors == 0) begin
      $display("osd_character_overlay_generator_top verification clean");
    end else begin
      $display("osd_character_overlay_generator_top verification failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result beat", 32'(out_if.covered), 32'd0);
      end else begin
        next_pixel = pending_pixels.pop_front();
        if (out_if.luma !== next_pixel.luma)
          report_mismatch("luma", 32'(out_if.luma), 32'(next_pixel.luma));
        if (out_if.chroma_u !== next_pixel.chroma_u)
          report_mismatch("chroma_u", 32'(out_if.chroma_u), 32'(next_pixel.chroma_u));
        if (out_if.chroma_v !== next_pixel.chroma_v)
          report_mismatch("chroma_v", 32'(out_if.chroma_v), 32'(next_pixel.chroma_v));
        if (out_if.alpha !== next_pixel.alpha)
          report_mismatch("alpha", 32'(out_if.alpha), 32'(next_pixel.alpha));
        if (out_if.covered !== next_pixel.covered)
          report_mismatch("covered", 32'(out_if.covered), 32'(next_pixel.covered));
        pixels_checked++;
        if (next_pixel.covered) covered_seen++;
      end
    end
  end

  // The result side switches among steady, light, heavy and near-blocked stalling.
  initial begin : result_stall
    int mode;
    int mode_left;
    out_if.ready <= 1'b0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 160);
      end else begin
        mode_left--;
      end
      case (mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= ($urandom_range(0, 1) != 0);
        default: out_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Timed out after %0d cycles with %0d results pending.",
                 cycle_count, pending_pixels.size());
        $display("osd_character_overlay_generator_top verification failed");
        $finish;
      end
    end
  end

endmodule
